// ----- hw/rtl/p8c_pkg.sv -----
// p8c_pkg: shared types and constants for the packed8 3x3 convolution engine.
// No dependencies.
`timescale 1ns / 1ps
package p8c_pkg;
  localparam int InputWords  = 8192;
  localparam int WeightWords = 8192;
  localparam int OutGroups   = 8;
  localparam int KernelSize  = 3;
  localparam int Lanes       = 8;
  localparam int BiasWords   = OutGroups * Lanes;
  localparam int InBankDepth = InputWords / Lanes;
  localparam int WtBankDepth = WeightWords / (Lanes * Lanes);
  localparam int IaW         = $clog2(InputWords);
  localparam int WaW         = $clog2(WeightWords);
  localparam int BaW         = $clog2(BiasWords);

  typedef enum logic [1:0] {
    FUNC_WR_INPUT  = 2'd0,
    FUNC_WR_WEIGHT = 2'd1,
    FUNC_WR_BIAS   = 2'd2,
    FUNC_COMPUTE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_WIDTH = 3'd0, REG_HEIGHT = 3'd1, REG_GROUPS = 3'd2, REG_SROWS = 3'd3,
    REG_SCOLS = 3'd4, REG_DROWS  = 3'd5, REG_DCOLS  = 3'd6, REG_BIAS   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [6:0] in_width;
    logic [6:0] in_height;
    logic [4:0] in_groups;
    logic [2:0] stride_rows;
    logic [2:0] stride_cols;
    logic [2:0] dil_rows;
    logic [2:0] dil_cols;
    logic       use_bias;
  } cfg_t;

  // one queued item
  typedef struct packed {
    logic [1:0]  func;
    logic [12:0] addr;
    logic [31:0] value;
    logic [5:0]  out_row;
    logic [5:0]  out_col;
    logic [2:0]  out_group;
  } item_t;

  localparam int ItemW = $bits(item_t);
endpackage

// ----- hw/rtl/p8c_cfg_regs.sv -----
// p8c_cfg_regs: APB-style configuration register file.
// Depends on p8c_pkg.
`timescale 1ns / 1ps
module p8c_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [4:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output p8c_pkg::cfg_t    cfg
);
  import p8c_pkg::*;
  cfg_t cfg_r;
  logic wr;
  reg_idx_t idx;
  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{in_width: 7'd1, in_height: 7'd1, in_groups: 5'd1, stride_rows: 3'd1,
                 stride_cols: 3'd1, dil_rows: 3'd1, dil_cols: 3'd1, use_bias: 1'b0};
    end else if (wr) begin
      case (idx)
        REG_WIDTH:  cfg_r.in_width    <= cfg_pwdata[6:0];
        REG_HEIGHT: cfg_r.in_height   <= cfg_pwdata[6:0];
        REG_GROUPS: cfg_r.in_groups   <= cfg_pwdata[4:0];
        REG_SROWS:  cfg_r.stride_rows <= cfg_pwdata[2:0];
        REG_SCOLS:  cfg_r.stride_cols <= cfg_pwdata[2:0];
        REG_DROWS:  cfg_r.dil_rows    <= cfg_pwdata[2:0];
        REG_DCOLS:  cfg_r.dil_cols    <= cfg_pwdata[2:0];
        REG_BIAS:   cfg_r.use_bias    <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  cfg_prdata = {25'd0, cfg_r.in_width};
      REG_HEIGHT: cfg_prdata = {25'd0, cfg_r.in_height};
      REG_GROUPS: cfg_prdata = {27'd0, cfg_r.in_groups};
      REG_SROWS:  cfg_prdata = {29'd0, cfg_r.stride_rows};
      REG_SCOLS:  cfg_prdata = {29'd0, cfg_r.stride_cols};
      REG_DROWS:  cfg_prdata = {29'd0, cfg_r.dil_rows};
      REG_DCOLS:  cfg_prdata = {29'd0, cfg_r.dil_cols};
      REG_BIAS:   cfg_prdata = {31'd0, cfg_r.use_bias};
      default:    cfg_prdata = 32'd0;
    endcase
  end
endmodule

// ----- hw/rtl/p8c_queue.sv -----
// p8c_queue: four-entry item queue between front and back.
// Depends on p8c_pkg.
`timescale 1ns / 1ps
module p8c_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  p8c_pkg::item_t       wr_item,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output p8c_pkg::item_t       rd_item
);
  import p8c_pkg::*;
  item_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic push, pop;
  assign wr_ready = cnt_r != 3'd4;
  assign rd_valid = cnt_r != 3'd0;
  assign rd_item  = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_item;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop)  rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, push} - {2'd0, pop};
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("queue count overflow");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 3'd1) else $error("queue count slip");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - 3'd1) else $error("queue count slip");
endmodule

// ----- hw/rtl/p8c_back.sv -----
// p8c_back: executes queued items: store writes and the tap-serial MAC walk.
// Depends on p8c_pkg.
`timescale 1ns / 1ps
module p8c_back (
  input  logic              clk,
  input  logic              rst_n,
  input  p8c_pkg::cfg_t     cfg,
  input  logic              q_valid,
  output logic              q_ready,
  input  p8c_pkg::item_t    q_item,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_value,
  output logic [2:0]        out_lane,
  output logic              out_last,
  output logic              out_error
);
  import p8c_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_BIAS, S_ADDR, S_READ, S_MUL, S_ACC, S_OUT} state_t;

  // banks per lane (weights by lane pair), each read at one address a cycle
  logic [15:0] in_mem  [Lanes][InBankDepth];
  logic [15:0] w_mem   [Lanes*Lanes][WtBankDepth];
  logic [31:0] b_mem   [Lanes][OutGroups];

  state_t st_r;
  item_t  it_r;
  logic [4:0]  g_r;
  logic [1:0]  kr_r, kc_r;
  logic        err_r;
  logic [2:0]  ol_r;
  logic signed [47:0] acc_r [Lanes];
  logic [15:0] xin_r [Lanes];
  logic [15:0] wv_r [Lanes*Lanes];
  logic signed [31:0] prod_r [Lanes*Lanes];
  logic [31:0] bias_r [Lanes];
  logic [23:0] ibase_r, wbase_r;
  logic [31:0] res;

  // address arithmetic for current tap
  logic [9:0]  rr, cc;
  logic [23:0] ib, wb;
  logic        oob;
  always_comb begin
    rr = 10'(it_r.out_row * cfg.stride_rows) + 10'(kr_r * cfg.dil_rows);
    cc = 10'(it_r.out_col * cfg.stride_cols) + 10'(kc_r * cfg.dil_cols);
    ib = 24'((24'(g_r) * cfg.in_height + 24'(rr)) * cfg.in_width + 24'(cc)) << 3;
    wb = 24'((24'(it_r.out_group) * cfg.in_groups + 24'(g_r)) * 24'(KernelSize*KernelSize)
         + 24'(kr_r) * 24'(KernelSize) + 24'(kc_r)) << 6;
    oob = (25'(ib) + 25'(Lanes) > 25'(InputWords)) ||
          (25'(wb) + 25'(Lanes*Lanes) > 25'(WeightWords));
  end

  assign q_ready = st_r == S_IDLE;
  assign out_tvalid = st_r == S_OUT;
  assign out_value = res;
  assign out_lane = ol_r;
  assign out_last = ol_r == 3'd7;
  assign out_error = err_r;

  logic take;
  assign take = q_valid && q_ready;

  // store writes
  always_ff @(posedge clk) begin
    if (take) begin
      case (func_t'(q_item.func))
        FUNC_WR_INPUT:
          in_mem[q_item.addr[2:0]][q_item.addr[12:3]] <= q_item.value[15:0];
        FUNC_WR_WEIGHT:
          w_mem[q_item.addr[5:0]][q_item.addr[12:6]] <= q_item.value[15:0];
        FUNC_WR_BIAS:
          if (q_item.addr < 13'(BiasWords))
            b_mem[q_item.addr[2:0]][q_item.addr[BaW-1:3]] <= q_item.value;
        default: ;
      endcase
    end
  end

  // banked reads, registered
  always_ff @(posedge clk) begin
    for (int i = 0; i < Lanes; i++) begin
      xin_r[i]  <= in_mem[i][ibase_r[12:3]];
      bias_r[i] <= b_mem[i][it_r.out_group];
    end
    for (int j = 0; j < Lanes*Lanes; j++) wv_r[j] <= w_mem[j][wbase_r[12:6]];
    for (int i = 0; i < Lanes; i++)
      for (int o = 0; o < Lanes; o++)
        prod_r[i*Lanes+o] <= $signed(xin_r[i]) * $signed(wv_r[i*Lanes+o]);
  end

  logic signed [47:0] sum_nxt [Lanes];
  always_comb begin
    for (int o = 0; o < Lanes; o++) begin
      sum_nxt[o] = acc_r[o];
      for (int i = 0; i < Lanes; i++) sum_nxt[o] = sum_nxt[o] + 48'(prod_r[i*Lanes+o]);
    end
  end

  logic signed [47:0] sel;
  assign sel = acc_r[ol_r];

  logic last_tap;
  assign last_tap = (kc_r == 2'(KernelSize-1)) && (kr_r == 2'(KernelSize-1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ol_r <= '0;
      err_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (take && q_item.func == FUNC_COMPUTE) begin
          it_r <= q_item; g_r <= '0; kr_r <= '0; kc_r <= '0; ol_r <= '0;
          err_r <= 1'b0;
          st_r <= S_BIAS;
        end
        S_BIAS: st_r <= S_ADDR; // bias read registered
        S_ADDR: begin
          // first tap seeds the sums with bias or zero
          if (g_r == 5'd0 && kr_r == 2'd0 && kc_r == 2'd0)
            for (int o = 0; o < Lanes; o++)
              acc_r[o] <= cfg.use_bias ? 48'($signed(bias_r[o])) : 48'sd0;
          if (g_r >= cfg.in_groups) begin
            st_r <= S_OUT;
          end else if (oob) begin
            err_r <= 1'b1; st_r <= S_OUT;
          end else begin
            ibase_r <= ib; wbase_r <= wb; st_r <= S_READ;
          end
        end
        S_READ: st_r <= S_MUL;
        S_MUL:  st_r <= S_ACC;
        S_ACC: begin
          for (int o = 0; o < Lanes; o++) acc_r[o] <= sum_nxt[o];
          if (kc_r == 2'(KernelSize-1)) begin
            kc_r <= '0;
            if (last_tap) begin kr_r <= '0; g_r <= g_r + 5'd1; end
            else kr_r <= kr_r + 2'd1;
          end else kc_r <= kc_r + 2'd1;
          st_r <= S_ADDR;
        end
        S_OUT: if (out_tready) begin
          ol_r <= ol_r + 3'd1;
          if (ol_r == 3'd7) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // saturation, or zero after an address error
  always_comb begin
    if (err_r) res = 32'd0;
    else if (sel > 48'sd2147483647) res = 32'h7fffffff;
    else if (sel < -48'sd2147483648) res = 32'h80000000;
    else res = sel[31:0];
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(ol_r)) else $error("lane slip");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> !take) else $error("took item while busy");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_last |=> st_r == S_IDLE) else $error("no return");
endmodule

// ----- hw/rtl/packed8_conv3x3_engine_core.sv -----
// Packed8 3x3 convolution engine, top level.
// Channels: in_* stream carries write or compute items; out_* stream returns
// eight lane results per compute item; cfg_* is an APB-style register port.
// A write item is stored when the back end takes it. A compute item walks
// its G*9 taps (G = in_groups) serially through the banked stores and the
// 8x8 multiplier array (address, read, multiply, accumulate per tap) before
// its first lane; the eight lane results then follow in order.
// A four-entry queue decouples the input stream from the back end.
// Reset (rst_n, synchronous) clears control and registers; stores are
// undefined until written. When the receiver stalls, the current lane holds
// and the queue fills, then in_tready drops.
// Depends on p8c_pkg, p8c_cfg_regs, p8c_queue, p8c_back.
`timescale 1ns / 1ps
module packed8_conv3x3_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // addr[12:0], value[44:13], out_row, out_col, out_group
  input  logic [1:0]  in_tuser,  // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // out_value[31:0], lane[34:32], error[35]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import p8c_pkg::*;
  cfg_t cfg;
  item_t wi, qi;
  logic qv, qr;
  logic [31:0] ov;
  logic [2:0] ol;
  logic oe;

  assign wi = '{func: in_tuser, addr: in_tdata[12:0], value: in_tdata[44:13],
                out_row: in_tdata[50:45], out_col: in_tdata[56:51],
                out_group: in_tdata[59:57]};

  p8c_cfg_regs u_cfg (.clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg(cfg));
  p8c_queue u_q (.clk, .rst_n, .wr_valid(in_tvalid), .wr_ready(in_tready), .wr_item(wi),
    .rd_valid(qv), .rd_ready(qr), .rd_item(qi));
  p8c_back u_back (.clk, .rst_n, .cfg(cfg), .q_valid(qv), .q_ready(qr), .q_item(qi),
    .out_tvalid, .out_tready, .out_value(ov), .out_lane(ol), .out_last(out_tlast),
    .out_error(oe));

  assign out_tdata = {4'd0, oe, ol, ov};
endmodule
